// ===== rtl/core/ansk_pkg.sv =====
package ansk_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_CSI,
		PH_K1,
		PH_K2
	} phase_t;

	localparam logic [2:0] KIND_PLAIN = 3'd0;
	localparam logic [2:0] KIND_ALT   = 3'd1;
	localparam logic [2:0] KIND_NAMED = 3'd2;
	localparam logic [2:0] KIND_FUNC  = 3'd3;
	localparam logic [2:0] KIND_ERR   = 3'd4;

	localparam logic [7:0] KEY_ESC = 8'd0;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_ONE   = 8'd49;
	localparam logic [7:0] CH_TWO   = 8'd50;
	localparam logic [7:0] CH_THREE = 8'd51;
	localparam logic [7:0] CH_SIX   = 8'd54;
	localparam logic [7:0] CH_SEVEN = 8'd55;
	localparam logic [7:0] CH_A     = 8'd65;
	localparam logic [7:0] CH_D     = 8'd68;
	localparam logic [7:0] CH_E     = 8'd69;
	localparam logic [7:0] CH_LBRK  = 8'd91;
	localparam logic [7:0] CH_TILDE = 8'd126;

	localparam logic [8:0] TMO_MARK = 9'd256;

	typedef struct packed {
		phase_t     phase;
		logic [8:0] first_code;
		logic [7:0] second_code;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] kind;
		logic [7:0] code;
	} dec_result_t;

endpackage

// ===== rtl/core/ansk_decode.sv =====
module ansk_decode
	import ansk_pkg::*;
(
	input  dec_state_t  cur,
	input  logic        tmo,
	input  logic [7:0]  b,
	output dec_state_t  nxt,
	output dec_result_t res
);

	logic [7:0] c8;
	logic       c_hi;
	logic [7:0] k;

	assign c8   = cur.first_code[7:0];
	assign c_hi = cur.first_code[8];
	assign k    = cur.second_code;

	always_comb begin
		nxt = cur;
		case (cur.phase)
			PH_ESC: begin
				if (!tmo && b == CH_LBRK) begin
					nxt.phase = PH_CSI;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_CSI: begin
				if (!tmo && b >= CH_A && b <= CH_D) begin
					nxt.phase = PH_IDLE;
				end else begin
					nxt.first_code = tmo ? TMO_MARK : {1'b0, b};
					nxt.phase      = PH_K1;
				end
			end
			PH_K1: begin
				if (tmo || b < CH_ZERO) begin
					nxt.phase = PH_IDLE;
				end else if (b == CH_TILDE && !c_hi && c8 >= CH_ONE && c8 <= CH_SIX) begin
					nxt.phase = PH_IDLE;
				end else if (!c_hi && c8 == CH_LBRK && b >= CH_A && b <= CH_E) begin
					nxt.phase = PH_IDLE;
				end else begin
					nxt.second_code = b;
					nxt.phase       = PH_K2;
				end
			end
			PH_K2: begin
				nxt.phase = PH_IDLE;
			end
			default: begin
				if (!tmo && b == CH_ESC) begin
					nxt.phase = PH_ESC;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		res = '{valid: 1'b0, kind: KIND_ERR, code: 8'd0};
		case (cur.phase)
			PH_ESC: begin
				if (tmo) begin
					res = '{valid: 1'b1, kind: KIND_NAMED, code: KEY_ESC};
				end else if (b != CH_LBRK) begin
					res = '{valid: 1'b1, kind: KIND_ALT, code: b};
				end
			end
			PH_CSI: begin
				if (!tmo && b >= CH_A && b <= CH_D) begin
					res = '{valid: 1'b1, kind: KIND_NAMED, code: b - 8'd64};
				end
			end
			PH_K1: begin
				if (tmo || b < CH_ZERO) begin
					res = '{valid: 1'b1, kind: KIND_ERR, code: 8'd0};
				end else if (b == CH_TILDE && !c_hi && c8 >= CH_ONE && c8 <= CH_SIX) begin
					res = '{valid: 1'b1, kind: KIND_NAMED, code: c8 - 8'd44};
				end else if (!c_hi && c8 == CH_LBRK && b >= CH_A && b <= CH_E) begin
					res = '{valid: 1'b1, kind: KIND_FUNC, code: b - 8'd64};
				end
			end
			PH_K2: begin
				res = '{valid: 1'b1, kind: KIND_ERR, code: 8'd0};
				if (!tmo && b == CH_TILDE && !c_hi) begin
					if (c8 == CH_ONE && k >= CH_SEVEN) begin
						res = '{valid: 1'b1, kind: KIND_FUNC, code: k - 8'd49};
					end else if (c8 == CH_TWO) begin
						res = '{valid: 1'b1, kind: KIND_FUNC, code: k - 8'd39};
					end else if (c8 == CH_THREE) begin
						res = '{valid: 1'b1, kind: KIND_FUNC, code: k - 8'd32};
					end
				end
			end
			default: begin
				if (!tmo && b != CH_ESC) begin
					res = '{valid: 1'b1, kind: KIND_PLAIN, code: (b == CH_CR) ? CH_LF : b};
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/escape_sequence_key_decoder_core.sv =====
// Console key escape-sequence decoder.
// Input channel: in_valid / in_ready with op (0 byte, 1 read timeout) and byte_in.
// Output channel: out_valid / out_ready with kind and code of one decoded key.
// Each input transfer yields zero or one result; bytes inside a sequence and
// timeouts while idle yield none.
// A result passes from its input transfer through the input register, then
// decode logic into the result register.
// Throughput: one input item per cycle unless the receiver stalls, set by the
// single pass of decode logic between the input register and the result register.
// When the receiver stalls, the result register holds, the item in the input
// register waits, and in_ready falls once both are full.
// Reset clears both valid flags and returns the decoder to idle with no
// sequence pending.
module escape_sequence_key_decoder_core
	import ansk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] code
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	logic [2:0]  kind_s2;
	logic [7:0]  code_s2;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        advance;

	ansk_decode u_decode (
		.cur (state_q),
		.tmo (op_s1),
		.b   (byte_s1),
		.nxt (state_nxt),
		.res (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '{phase: PH_IDLE, first_code: 9'd0, second_code: 8'd0};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= state_nxt;
			valid_s2 <= res.valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_s2 <= res.kind;
			code_s2 <= res.code;
		end
	end

	assign out_valid = valid_s2;
	assign kind      = kind_s2;
	assign code      = code_s2;

endmodule
